// ===== src/aat_pkg.sv =====
// Shared types and constants for the affine box transform.
// The datapath widths, the register map and the pipeline control struct live here.
// No dependencies.
package aat_pkg;

    localparam int DATA_W    = 32;
    localparam int PROD_W    = 64;
    localparam int FRAC_W    = 16;
    localparam int TERM_W    = PROD_W - FRAC_W;
    localparam int SUM_W     = TERM_W + 2;
    localparam int CFG_W     = 64;
    localparam int NUM_REGS  = 6;
    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] REG_X_AB = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_X_CT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_Y_AB = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_Y_CT = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_Z_AB = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_Z_CT = 3'd5;

    localparam logic [CFG_W-1:0] CFG_RESET [NUM_REGS] = '{
        64'h0000_0000_0001_0000, 64'h0000_0000_0000_0000,
        64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000,
        64'h0000_0000_0000_0000, 64'h0000_0000_0001_0000
    };

    typedef struct packed {
        logic signed [DATA_W-1:0] coef_x;
        logic signed [DATA_W-1:0] coef_y;
        logic signed [DATA_W-1:0] coef_z;
        logic signed [DATA_W-1:0] trans;
    } t_row;

    typedef struct packed {
        logic en_mul;
        logic en_term;
        logic en_sum;
        logic en_out;
    } t_pipe_ctl;

endpackage

// ===== src/aat_cfg_regs.sv =====
// Configuration register file of the affine box transform: six 64-bit registers.
// Unpacks them into one coefficient row per output axis. Depends on aat_pkg.
module aat_cfg_regs (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_wr,
    input  logic [aat_pkg::CFG_IDX_W-1:0]        i_index,
    input  logic [aat_pkg::CFG_W-1:0]            i_data,
    output aat_pkg::t_row                        o_row_x,
    output aat_pkg::t_row                        o_row_y,
    output aat_pkg::t_row                        o_row_z
);

    logic [aat_pkg::CFG_W-1:0] r_regs [aat_pkg::NUM_REGS];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_regs <= aat_pkg::CFG_RESET;
        end else if (i_wr && (i_index <= aat_pkg::REG_Z_CT)) begin
            r_regs[i_index] <= i_data;
        end
    end

    always_comb begin
        o_row_x.coef_x = r_regs[aat_pkg::REG_X_AB][31:0];
        o_row_x.coef_y = r_regs[aat_pkg::REG_X_AB][63:32];
        o_row_x.coef_z = r_regs[aat_pkg::REG_X_CT][31:0];
        o_row_x.trans  = r_regs[aat_pkg::REG_X_CT][63:32];
        o_row_y.coef_x = r_regs[aat_pkg::REG_Y_AB][31:0];
        o_row_y.coef_y = r_regs[aat_pkg::REG_Y_AB][63:32];
        o_row_y.coef_z = r_regs[aat_pkg::REG_Y_CT][31:0];
        o_row_y.trans  = r_regs[aat_pkg::REG_Y_CT][63:32];
        o_row_z.coef_x = r_regs[aat_pkg::REG_Z_AB][31:0];
        o_row_z.coef_y = r_regs[aat_pkg::REG_Z_AB][63:32];
        o_row_z.coef_z = r_regs[aat_pkg::REG_Z_CT][31:0];
        o_row_z.trans  = r_regs[aat_pkg::REG_Z_CT][63:32];
    end

endmodule

// ===== src/aat_axis_pipe.sv =====
// Four-stage datapath for one output axis: products, floor and min/max per term,
// sums, then saturation into the output register. Depends on aat_pkg.
module aat_axis_pipe (
    input  logic                                 i_clk,
    input  aat_pkg::t_pipe_ctl                   i_ctl,
    input  aat_pkg::t_row                        i_row,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_lo_x,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_lo_y,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_lo_z,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_hi_x,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_hi_y,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_hi_z,
    output logic signed [aat_pkg::DATA_W-1:0]    o_lo,
    output logic signed [aat_pkg::DATA_W-1:0]    o_hi,
    output logic                                 o_sat
);

    localparam int EXT_W = aat_pkg::SUM_W - aat_pkg::TERM_W;
    localparam int TOP_W = aat_pkg::SUM_W - aat_pkg::DATA_W + 1;

    logic signed [aat_pkg::PROD_W-1:0] n_p_lo [3];
    logic signed [aat_pkg::PROD_W-1:0] n_p_hi [3];
    logic signed [aat_pkg::PROD_W-1:0] r_p_lo [3];
    logic signed [aat_pkg::PROD_W-1:0] r_p_hi [3];
    logic signed [aat_pkg::TERM_W-1:0] n_t_min [3];
    logic signed [aat_pkg::TERM_W-1:0] n_t_max [3];
    logic signed [aat_pkg::TERM_W-1:0] r_t_min [3];
    logic signed [aat_pkg::TERM_W-1:0] r_t_max [3];
    logic signed [aat_pkg::SUM_W-1:0]  n_s_min;
    logic signed [aat_pkg::SUM_W-1:0]  n_s_max;
    logic signed [aat_pkg::SUM_W-1:0]  r_s_min;
    logic signed [aat_pkg::SUM_W-1:0]  r_s_max;
    logic signed [aat_pkg::SUM_W-1:0]  w_trans;
    logic signed [aat_pkg::DATA_W-1:0] n_lo;
    logic signed [aat_pkg::DATA_W-1:0] n_hi;
    logic                              n_sat;
    logic signed [aat_pkg::DATA_W-1:0] r_lo;
    logic signed [aat_pkg::DATA_W-1:0] r_hi;
    logic                              r_sat;
    logic                              w_ovf_lo;
    logic                              w_ovf_hi;

    function automatic logic signed [aat_pkg::SUM_W-1:0] sext_term(
        input logic signed [aat_pkg::TERM_W-1:0] t
    );
        return {{EXT_W{t[aat_pkg::TERM_W-1]}}, t};
    endfunction

    function automatic logic overflows(input logic signed [aat_pkg::SUM_W-1:0] s);
        logic [TOP_W-1:0] top;
        top = s[aat_pkg::SUM_W-1:aat_pkg::DATA_W-1];
        return !((&top) || !(|top));
    endfunction

    function automatic logic signed [aat_pkg::DATA_W-1:0] clip(
        input logic signed [aat_pkg::SUM_W-1:0] s
    );
        logic signed [aat_pkg::DATA_W-1:0] res;
        if (!overflows(s)) begin
            res = s[aat_pkg::DATA_W-1:0];
        end else if (s[aat_pkg::SUM_W-1]) begin
            res = {1'b1, {(aat_pkg::DATA_W-1){1'b0}}};
        end else begin
            res = {1'b0, {(aat_pkg::DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

    always_comb begin
        n_p_lo[0] = i_row.coef_x * i_lo_x;
        n_p_lo[1] = i_row.coef_y * i_lo_y;
        n_p_lo[2] = i_row.coef_z * i_lo_z;
        n_p_hi[0] = i_row.coef_x * i_hi_x;
        n_p_hi[1] = i_row.coef_y * i_hi_y;
        n_p_hi[2] = i_row.coef_z * i_hi_z;
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            if (r_p_lo[k] < r_p_hi[k]) begin
                n_t_min[k] = r_p_lo[k][aat_pkg::PROD_W-1:aat_pkg::FRAC_W];
                n_t_max[k] = r_p_hi[k][aat_pkg::PROD_W-1:aat_pkg::FRAC_W];
            end else begin
                n_t_min[k] = r_p_hi[k][aat_pkg::PROD_W-1:aat_pkg::FRAC_W];
                n_t_max[k] = r_p_lo[k][aat_pkg::PROD_W-1:aat_pkg::FRAC_W];
            end
        end
    end

    assign w_trans = {{(aat_pkg::SUM_W-aat_pkg::DATA_W){i_row.trans[aat_pkg::DATA_W-1]}},
                      i_row.trans};

    always_comb begin
        n_s_min = sext_term(r_t_min[0]) + sext_term(r_t_min[1])
                + sext_term(r_t_min[2]) + w_trans;
        n_s_max = sext_term(r_t_max[0]) + sext_term(r_t_max[1])
                + sext_term(r_t_max[2]) + w_trans;
    end

    always_comb begin
        w_ovf_lo = overflows(r_s_min);
        w_ovf_hi = overflows(r_s_max);
        n_lo     = clip(r_s_min);
        n_hi     = clip(r_s_max);
        n_sat    = w_ovf_lo || w_ovf_hi;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en_mul) begin
            r_p_lo <= n_p_lo;
            r_p_hi <= n_p_hi;
        end
        if (i_ctl.en_term) begin
            r_t_min <= n_t_min;
            r_t_max <= n_t_max;
        end
        if (i_ctl.en_sum) begin
            r_s_min <= n_s_min;
            r_s_max <= n_s_max;
        end
        if (i_ctl.en_out) begin
            r_lo  <= n_lo;
            r_hi  <= n_hi;
            r_sat <= n_sat;
        end
    end

    assign o_lo  = r_lo;
    assign o_hi  = r_hi;
    assign o_sat = r_sat;

endmodule

// ===== src/aat_valid_ctl.sv =====
// Valid-bit chain and stall control of the four-stage transform pipeline.
// Produces per-stage load enables as a control struct. Depends on aat_pkg.
module aat_valid_ctl (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic               i_stall,
    output logic               o_stall,
    output logic               o_valid,
    output aat_pkg::t_pipe_ctl o_ctl
);

    logic [3:0] r_vld;
    logic [3:0] n_vld;
    logic [3:0] w_adv;

    always_comb begin
        w_adv[3] = !r_vld[3] || !i_stall;
        w_adv[2] = !r_vld[2] || w_adv[3];
        w_adv[1] = !r_vld[1] || w_adv[2];
        w_adv[0] = !r_vld[0] || w_adv[1];
        n_vld    = r_vld;
        if (w_adv[0]) begin
            n_vld[0] = i_valid;
        end
        for (int k = 1; k < 4; k++) begin
            if (w_adv[k]) begin
                n_vld[k] = r_vld[k-1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= n_vld;
        end
    end

    assign o_ctl.en_mul  = w_adv[0];
    assign o_ctl.en_term = w_adv[1];
    assign o_ctl.en_sum  = w_adv[2];
    assign o_ctl.en_out  = w_adv[3];
    assign o_stall       = !w_adv[0];
    assign o_valid       = r_vld[3];

endmodule

// ===== src/aabb_affine_transform.sv =====
// Top level of the affine box transform: register file, control and three axis datapaths.
// Depends on aat_pkg, aat_cfg_regs, aat_valid_ctl and aat_axis_pipe.
//
// Usage: one input word is a box (min and max corners, signed Q16.16). The block
// maps the box through the configured 3x4 affine matrix and returns the bounding
// box of the eight mapped corners, with a flag set if any coordinate saturated.
// The input channel is i_valid with o_stall; the output channel is o_valid with
// i_stall. A word moves when valid is high and stall is low.
// Configuration is written on i_cfg_valid with i_cfg_index and i_cfg_data; the
// port is always ready, indexes above five are ignored, and writes must only be
// made while no word is in flight.
// An accepted input word passes the product, term, sum and output registers to its
// output word. One word is accepted every cycle while o_stall is low, through the
// four-stage pipeline of multipliers, term selection, adders and saturation.
// When the receiver stalls, the output register holds its word and stages fill
// in turn; o_stall rises only when all four stages hold words.
// Reset empties the pipeline and loads the identity transform.
module aabb_affine_transform (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_valid,
    output logic                                 o_stall,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_lo_x,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_lo_y,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_lo_z,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_hi_x,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_hi_y,
    input  logic signed [aat_pkg::DATA_W-1:0]    i_hi_z,
    output logic                                 o_valid,
    input  logic                                 i_stall,
    output logic signed [aat_pkg::DATA_W-1:0]    o_out_lo_x,
    output logic signed [aat_pkg::DATA_W-1:0]    o_out_lo_y,
    output logic signed [aat_pkg::DATA_W-1:0]    o_out_lo_z,
    output logic signed [aat_pkg::DATA_W-1:0]    o_out_hi_x,
    output logic signed [aat_pkg::DATA_W-1:0]    o_out_hi_y,
    output logic signed [aat_pkg::DATA_W-1:0]    o_out_hi_z,
    output logic                                 o_saturated,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [aat_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [aat_pkg::CFG_W-1:0]            i_cfg_data
);

    aat_pkg::t_row      w_row_x;
    aat_pkg::t_row      w_row_y;
    aat_pkg::t_row      w_row_z;
    aat_pkg::t_pipe_ctl w_ctl;
    logic               w_sat_x;
    logic               w_sat_y;
    logic               w_sat_z;

    assign o_cfg_ready = 1'b1;

    aat_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (i_cfg_valid && o_cfg_ready),
        .i_index (i_cfg_index),
        .i_data  (i_cfg_data),
        .o_row_x (w_row_x),
        .o_row_y (w_row_y),
        .o_row_z (w_row_z)
    );

    aat_valid_ctl u_ctl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .i_stall (i_stall),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .o_ctl   (w_ctl)
    );

    aat_axis_pipe u_axis_x (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_row  (w_row_x),
        .i_lo_x (i_lo_x),
        .i_lo_y (i_lo_y),
        .i_lo_z (i_lo_z),
        .i_hi_x (i_hi_x),
        .i_hi_y (i_hi_y),
        .i_hi_z (i_hi_z),
        .o_lo   (o_out_lo_x),
        .o_hi   (o_out_hi_x),
        .o_sat  (w_sat_x)
    );

    aat_axis_pipe u_axis_y (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_row  (w_row_y),
        .i_lo_x (i_lo_x),
        .i_lo_y (i_lo_y),
        .i_lo_z (i_lo_z),
        .i_hi_x (i_hi_x),
        .i_hi_y (i_hi_y),
        .i_hi_z (i_hi_z),
        .o_lo   (o_out_lo_y),
        .o_hi   (o_out_hi_y),
        .o_sat  (w_sat_y)
    );

    aat_axis_pipe u_axis_z (
        .i_clk  (i_clk),
        .i_ctl  (w_ctl),
        .i_row  (w_row_z),
        .i_lo_x (i_lo_x),
        .i_lo_y (i_lo_y),
        .i_lo_z (i_lo_z),
        .i_hi_x (i_hi_x),
        .i_hi_y (i_hi_y),
        .i_hi_z (i_hi_z),
        .o_lo   (o_out_lo_z),
        .o_hi   (o_out_hi_z),
        .o_sat  (w_sat_z)
    );

    assign o_saturated = w_sat_x || w_sat_y || w_sat_z;

`ifndef ASSERT_OFF
    a_stall_needs_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (o_valid && i_stall && !w_ctl.en_sum && !w_ctl.en_term))
        else $error("input stalled while the pipeline has room");

    a_enables_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctl.en_out |-> (w_ctl.en_sum && w_ctl.en_term && w_ctl.en_mul))
        else $error("upstream stage held while the output stage advances");

    a_out_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_out_lo_x <= o_out_hi_x && o_out_lo_y <= o_out_hi_y
                     && o_out_lo_z <= o_out_hi_z))
        else $error("output box is not ordered");
`endif

endmodule
